// ===== hw/rtl/csv_record_parser_macros.svh =====
// Assertion macros for the checker file of the CSV record parser.
`ifndef CSV_RECORD_PARSER_MACROS_SVH
`define CSV_RECORD_PARSER_MACROS_SVH

// A check that is switched off while reset is held.
`define CSVRP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("csv_record_parser: check failed");

// A check that also applies while reset is held.
`define CSVRP_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("csv_record_parser: reset check failed");

`endif

// ===== hw/rtl/csvrp_pkg.sv =====
// Types and constants shared by the CSV record parser modules.
package csvrp_pkg;

  localparam int unsigned MAX_FIELDS = 256;

  // Highest field index that can be reported; the index saturates here.
  localparam logic [7:0] INDEX_CAP =
    ((MAX_FIELDS - 1) < 255) ? 8'(MAX_FIELDS - 1) : 8'd255;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] DELIM_RESET = 8'd44;

  typedef enum logic [2:0] {
    PH_START,
    PH_UNQ,
    PH_QUO,
    PH_QPEND,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_line;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic       record_end;
    logic [7:0] field_index;
    logic       field_overflow;
  } out_word_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] field_counter;
    logic       overflow;
  } parse_state_t;

  localparam parse_state_t PARSE_STATE_RESET = '{
    phase:         PH_START,
    field_counter: 8'd0,
    overflow:      1'b0
  };

endpackage

// ===== hw/rtl/csvrp_step.sv =====
// Next-state and result logic of the CSV record parser for one word.
module csvrp_step (
  input  csvrp_pkg::parse_state_t state,
  input  logic [7:0]              delimiter,
  input  csvrp_pkg::in_word_t     word,
  output csvrp_pkg::parse_state_t state_next,
  output logic                    emit,
  output csvrp_pkg::out_word_t    result
);
  import csvrp_pkg::*;

  logic [7:0] b;
  logic       is_delim;
  logic       is_term;
  logic       open_next;
  logic       start_field;

  assign b        = word.in_byte;
  assign is_delim = (b == delimiter);
  // A zero byte ends the line; CR and LF end it unless they are the delimiter.
  assign is_term  = (b == CH_NUL) || (!is_delim && ((b == CH_CR) || (b == CH_LF)));

  always_comb begin
    state_next            = state;
    emit                  = 1'b0;
    start_field           = 1'b0;
    open_next             = 1'b0;
    result.out_byte       = 8'd0;
    result.byte_valid     = 1'b0;
    result.field_end      = 1'b0;
    result.record_end     = 1'b0;
    result.field_index    = state.field_counter;
    result.field_overflow = state.overflow;

    if (word.end_of_line) begin
      emit              = (state.phase != PH_DONE);
      result.field_end  = 1'b1;
      result.record_end = 1'b1;
      state_next        = PARSE_STATE_RESET;
    end else begin
      case (state.phase)
        PH_START, PH_UNQ: begin
          if ((state.phase == PH_START) && (b == CH_QUOTE)) begin
            state_next.phase = PH_QUO;
          end else if (is_term) begin
            emit              = 1'b1;
            result.field_end  = 1'b1;
            result.record_end = 1'b1;
            state_next.phase  = PH_DONE;
          end else if (is_delim) begin
            emit             = 1'b1;
            result.field_end = 1'b1;
            start_field      = 1'b1;
          end else begin
            emit              = 1'b1;
            result.out_byte   = b;
            result.byte_valid = 1'b1;
            state_next.phase  = PH_UNQ;
          end
        end
        PH_QUO: begin
          if (b == CH_NUL) begin
            emit              = 1'b1;
            result.field_end  = 1'b1;
            result.record_end = 1'b1;
            state_next.phase  = PH_DONE;
          end else if (b == CH_QUOTE) begin
            state_next.phase = PH_QPEND;
          end else begin
            emit              = 1'b1;
            result.out_byte   = b;
            result.byte_valid = 1'b1;
          end
        end
        PH_QPEND: begin
          emit = 1'b1;
          if (b == CH_QUOTE) begin
            result.out_byte   = CH_QUOTE;
            result.byte_valid = 1'b1;
            state_next.phase  = PH_QUO;
          end else if ((b != CH_NUL) && is_delim) begin
            result.field_end = 1'b1;
            start_field      = 1'b1;
          end else begin
            result.field_end  = 1'b1;
            result.record_end = 1'b1;
            state_next.phase  = PH_DONE;
          end
        end
        PH_DONE: begin
          state_next.phase = PH_DONE;
        end
        default: begin
          state_next.phase = PH_DONE;
        end
      endcase

      open_next = start_field;
      if (open_next) begin
        state_next.phase = PH_START;
        if (state.field_counter >= INDEX_CAP) begin
          state_next.field_counter = INDEX_CAP;
          state_next.overflow      = 1'b1;
        end else begin
          state_next.field_counter = state.field_counter + 8'd1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/csv_record_parser.sv =====
// Top level of the CSV record parser: handshakes, delimiter register and result register.
// The parser takes a line of text one byte word at a time, closed by an end-of-line
// word, and splits it into fields at the delimiter byte held in the configuration
// register (comma after reset). Each accepted word yields at most one result word: a
// content byte of the current field, a field-end mark, or a field-end mark together
// with a record-end mark. Opening quotes, the first quote of a doubled pair, a closing
// quote still waiting for its next byte, and bytes after the record has ended yield no
// result word. The design takes one input word per clock cycle sustained while results
// are taken: the parse state is updated in the cycle a word is accepted, and the result
// goes into a single output register, so a word can be accepted in the same cycle that
// the previous result is taken. A result is visible in the cycle after its word is
// accepted. The delimiter register should only be written while no word is in flight.
module csv_record_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  csvrp_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output csvrp_pkg::out_word_t out_data
);
  import csvrp_pkg::*;

  logic         [7:0] delimiter;
  parse_state_t       state;
  parse_state_t       state_next;
  logic               emit;
  out_word_t          result;
  logic               in_accept;

  // The output register may be reloaded whenever it is empty or being emptied.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  csvrp_step u_step (
    .state      (state),
    .delimiter  (delimiter),
    .word       (in_data),
    .state_next (state_next),
    .emit       (emit),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= DELIM_RESET;
      state     <= PARSE_STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        delimiter <= cfg_wr_data;
      end
      if (in_accept) begin
        state <= state_next;
      end
      // A word that yields no result leaves the output register empty.
      if (in_ready) begin
        out_valid <= in_accept && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_data <= result;
    end
  end

endmodule

// ===== hw/rtl/csvrp_checker.sv =====
// Port-level checks of the CSV record parser and their binding to the top level.
`include "csv_record_parser_macros.svh"

module csvrp_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input csvrp_pkg::out_word_t out_data
);
  import csvrp_pkg::*;

  logic marks_ok;

  // A record only ends together with its last field, and never on a content byte.
  assign marks_ok = (!out_data.record_end || out_data.field_end) &&
                    !(out_data.byte_valid && out_data.field_end);

  // A held result does not change until it is taken.
  `CSVRP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // An empty output register never blocks the input side.
  `CSVRP_ASSERT(a_ready_when_empty, !out_valid |-> in_ready)

  `CSVRP_ASSERT(a_marks, out_valid |-> marks_ok)

  // The overflow flag is only reported once the index has saturated.
  `CSVRP_ASSERT(a_overflow_cap, out_valid && out_data.field_overflow |-> out_data.field_index == INDEX_CAP)

  // Reset empties the output register.
  `CSVRP_ASSERT_RST(a_reset_empty, rst |=> !out_valid)

endmodule

bind csv_record_parser csvrp_checker u_checker (.*);
